@@ sv/piecewise_linear_table_lookup_top_assert.svh @@
// Assertion macros shared by the lookup table checker.
`ifndef PIECEWISE_LINEAR_TABLE_LOOKUP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/plt_pkg.sv @@
// Shared types, constants and sequencer states of the lookup table block.
package plt_pkg;

    localparam int PLT_MAX_POINTS = 16;
    localparam int ANGLE_W        = 31;
    localparam int CTRL_W         = 16;
    localparam int INDEX_W        = 4;
    localparam int COUNT_W        = 5;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 5'd2;
    localparam logic [COUNT_W-1:0] POINT_COUNT_MIN = 5'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [CTRL_W-1:0]  t_ctrl;

    // One table segment handed to the halving unit.
    typedef struct packed {
        t_angle x1;
        t_angle x2;
        t_ctrl  y1;
        t_ctrl  y2;
    } t_seg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_INTERP,
        S_DONE
    } t_state;

endpackage

@@ sv/plt_ram.sv @@
// Generic single-port RAM with registered read data.
module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/plt_halver.sv @@
// Successive-halving interpolation unit: one halving step per cycle.
module plt_halver
    import plt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_seg   i_seg,
    input  t_angle i_query,
    output logic   o_done,
    output t_ctrl  o_result
);

    logic   r_busy;
    t_angle r_x1;
    t_angle r_x2;
    t_ctrl  r_y1;
    t_ctrl  r_y2;

    logic [ANGLE_W:0]   span;
    logic [ANGLE_W:0]   offs;
    logic [ANGLE_W-1:0] dx;
    logic [CTRL_W:0]    dctl;
    logic [CTRL_W-1:0]  dy;
    logic               go_up;

    // span and offset are never negative: x1 <= query <= x2 holds throughout
    assign span  = {r_x2[ANGLE_W-1], r_x2} - {r_x1[ANGLE_W-1], r_x1};
    assign offs  = {i_query[ANGLE_W-1], i_query} - {r_x1[ANGLE_W-1], r_x1};
    assign dx    = span[ANGLE_W:1];
    assign dctl  = {r_y2[CTRL_W-1], r_y2} - {r_y1[CTRL_W-1], r_y1};
    assign dy    = dctl[CTRL_W:1];  // floor halving of the control span
    assign go_up = offs > {1'b0, dx};

    assign o_done   = r_busy && (dx == '0);
    assign o_result = (i_query == r_x1) ? r_y1 : r_y2;

    // busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // segment registers: load on start, then shrink toward the query
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x1 <= i_seg.x1;
            r_x2 <= i_seg.x2;
            r_y1 <= i_seg.y1;
            r_y2 <= i_seg.y2;
        end else if (r_busy && !o_done) begin
            if (go_up) begin
                r_x1 <= r_x1 + dx;
                r_y1 <= r_y1 + dy;
            end else begin
                r_x2 <= r_x2 - dx;
                r_y2 <= r_y2 - dy;
            end
        end
    end

endmodule

@@ sv/piecewise_linear_table_lookup_top.sv @@
// Top level: breakpoint table RAM, segment search sequencer and output register.
//
// Input channel (i_in_valid / o_in_ready): a transfer with i_command = write stores
// i_entry_angle and i_entry_control at i_entry_index and gives no result; indexes at
// or above MAX_POINTS are dropped. A lookup transfer yields one o_control_value on
// the output channel (o_out_valid / i_out_ready).
// i_cfg_we / i_cfg_data set the number of breakpoints in use (clamped to
// 2..MAX_POINTS). Entries must be written before a lookup reads them.
// Sequence: a write is stored from the idle state. A lookup runs clamp checks against
// the first and last entries, scans the table downward from the top for the segment,
// then steps the halving unit and registers the result. The single-port table RAM
// (one read per cycle) sets the scan rate; the halving unit sets the rest.
// The result sits in an output register: if the receiver stalls, the next item is
// still taken, and a second lookup result waits in the sequencer until the register
// frees. Reset clears the sequencer, the output valid and the point count (to 2);
// table contents are not cleared.
module piecewise_linear_table_lookup_top
    import plt_pkg::*;
#(
    parameter int MAX_POINTS = PLT_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  t_angle             i_entry_angle,
    input  t_ctrl              i_entry_control,
    input  t_angle             i_query_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_ctrl              o_control_value,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = ANGLE_W + CTRL_W;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_point_count;
    logic [AW-1:0]      r_idx, n_idx;
    t_angle             r_q;
    t_angle             r_x2, n_x2;
    t_ctrl              r_y2, n_y2;
    t_ctrl              r_res, n_res;
    logic               r_out_valid;
    t_ctrl              r_out_value;

    logic          in_xfer;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_rdata;
    t_angle        rd_angle;
    t_ctrl         rd_ctrl;
    logic [AW-1:0] last_idx;
    logic          idx_ok;
    logic          hv_start;
    logic          hv_done;
    t_ctrl         hv_result;
    t_seg          hv_seg;
    logic          out_load;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign rd_angle = ram_rdata[DW-1:CTRL_W];
    assign rd_ctrl  = ram_rdata[CTRL_W-1:0];
    assign idx_ok   = int'(i_entry_index) < MAX_POINTS;

    // top entry in use, from the clamped point count
    always_comb begin
        if (r_point_count < POINT_COUNT_MIN) begin
            last_idx = AW'(1);
        end else if (int'(r_point_count) > MAX_POINTS) begin
            last_idx = AW'(MAX_POINTS - 1);
        end else begin
            last_idx = AW'(r_point_count - 5'd1);
        end
    end

    // breakpoint table: angle in the upper bits, control in the lower bits
    plt_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({i_entry_angle, i_entry_control}),
        .o_rdata(ram_rdata)
    );

    assign hv_seg = '{x1: rd_angle, x2: r_x2, y1: rd_ctrl, y2: r_y2};

    plt_halver u_halver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hv_start),
        .i_seg   (hv_seg),
        .i_query (r_q),
        .o_done  (hv_done),
        .o_result(hv_result)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_command == CMD_LOOKUP) begin
                    n_state = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST: begin
                n_state = (r_q < rd_angle) ? S_DONE : S_CHK_LAST;
            end
            S_CHK_LAST: begin
                n_state = (r_q > rd_angle) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (!(r_idx > AW'(1) && r_q < rd_angle)) begin
                    n_state = S_INTERP;
                end
            end
            S_INTERP: begin
                if (hv_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: RAM access, halver start and datapath next values
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = '0;
        hv_start   = 1'b0;
        out_load   = 1'b0;
        n_idx      = r_idx;
        n_x2       = r_x2;
        n_y2       = r_y2;
        n_res      = r_res;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_command == CMD_WRITE) begin
                    ram_addr = AW'(i_entry_index);
                    ram_we   = in_xfer && idx_ok;
                end
            end
            S_CHK_FIRST: begin
                // below the first breakpoint clamps to its control
                n_res    = rd_ctrl;
                ram_addr = last_idx;
            end
            S_CHK_LAST: begin
                // above the last breakpoint clamps to its control
                n_res    = rd_ctrl;
                n_x2     = rd_angle;
                n_y2     = rd_ctrl;
                n_idx    = last_idx;
                ram_addr = AW'(last_idx - AW'(1));
            end
            S_SCAN: begin
                if (r_idx > AW'(1) && r_q < rd_angle) begin
                    n_x2     = rd_angle;
                    n_y2     = rd_ctrl;
                    n_idx    = AW'(r_idx - AW'(1));
                    ram_addr = AW'(r_idx - AW'(2));
                end else begin
                    hv_start = 1'b1;
                end
            end
            S_INTERP: begin
                if (hv_done) begin
                    n_res = hv_result;
                end
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= POINT_COUNT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_q <= i_query_angle;
        end
        r_idx <= n_idx;
        r_x2  <= n_x2;
        r_y2  <= n_y2;
        r_res <= n_res;
        if (out_load) begin
            r_out_value <= r_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_control_value = r_out_value;

endmodule

@@ sv/plt_checker.sv @@
// Port-level checker for the lookup table block, bound to the top level.
`include "piecewise_linear_table_lookup_top_assert.svh"

module plt_checker
    import plt_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_ready,
    input logic  i_command,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_ctrl o_control_value
);

    // a stalled result stays offered
    `PLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // a stalled result keeps its value
    `PLT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_control_value), "result changed while stalled")

    // a lookup transfer makes the block busy in the next cycle
    `PLT_ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_command == CMD_LOOKUP, !o_in_ready, "ready after lookup transfer")

    // a write transfer finishes at once
    `PLT_ASSERT_NEXT(a_write_ready, i_clk, i_rst_n, i_in_valid && o_in_ready && i_command == CMD_WRITE, o_in_ready, "not ready after write transfer")

    // a new result appears only out of a busy period
    `PLT_ASSERT_NOW(a_result_src, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready), "result without a lookup")

endmodule

bind piecewise_linear_table_lookup_top plt_checker u_plt_checker (.*);

@@ dv/tb_piecewise_linear_table_lookup_top.sv @@
// Testbench for the piecewise linear lookup table: directed and random transfers, scoreboard check.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_lookup_top;
    import plt_pkg::*;

    localparam int     CLK_PERIOD     = 10;
    localparam longint ANGLE_MIN      = -(longint'(1) << (ANGLE_W - 1));
    localparam longint ANGLE_MAX      = (longint'(1) << (ANGLE_W - 1)) - 1;
    localparam int     CTRL_MIN       = -(1 << (CTRL_W - 1));
    localparam int     CTRL_MAX       = (1 << (CTRL_W - 1)) - 1;
    localparam int     NUM_PHASES     = 10;
    localparam int     PHASE_ITEMS    = 119;
    localparam int     SETTLE_CYCLES  = 60;
    localparam int     LONG_HOLD      = 400;
    localparam int     WATCHDOG_LIMIT = 5000;

    // Shapes of breakpoint table loaded at the start of a phase
    typedef enum int {
        FILL_SPREAD,
        FILL_FULL_SPAN,
        FILL_DENSE,
        FILL_SCRAMBLED
    } t_fill;

    // Mirrors the breakpoint table and predicts one control value per lookup
    class lookup_scoreboard;
        t_angle             bp_angle[PLT_MAX_POINTS];
        t_ctrl              bp_ctrl[PLT_MAX_POINTS];
        logic [COUNT_W-1:0] points;
        t_ctrl              expected_controls[$];
        int                 writes_seen;
        int                 lookups_seen;
        int                 results_checked;
        int                 errors;

        function new();
            points          = POINT_COUNT_RST;
            writes_seen     = 0;
            lookups_seen    = 0;
            results_checked = 0;
            errors          = 0;
        endfunction

        function void load_points(logic [COUNT_W-1:0] v);
            points = v;
        endfunction

        function int pending();
            return expected_controls.size();
        endfunction

        // Clamp at the ends, scan down for the segment, then halve spans
        function t_ctrl interp_control(t_angle q);
            int unsigned n;
            int unsigned i;
            longint      x;
            longint      x1;
            longint      x2;
            longint      y1;
            longint      y2;
            longint      dx;
            longint      dy;
            n = points;
            if (n < POINT_COUNT_MIN) n = POINT_COUNT_MIN;
            if (n > PLT_MAX_POINTS) n = PLT_MAX_POINTS;
            x = q;
            if (x < longint'(bp_angle[0])) return bp_ctrl[0];
            if (x > longint'(bp_angle[n-1])) return bp_ctrl[n-1];
            i = n - 1;
            while (i > 1 && x < longint'(bp_angle[i-1])) i--;
            x1 = bp_angle[i-1];
            x2 = bp_angle[i];
            y1 = bp_ctrl[i-1];
            y2 = bp_ctrl[i];
            while ((x2 - x1) / 2 != 0) begin
                dx = (x2 - x1) / 2;
                dy = (y2 - y1) >>> 1;
                if (x - x1 > dx) begin
                    x1 += dx;
                    y1 += dy;
                end else begin
                    x2 -= dx;
                    y2 -= dy;
                end
            end
            return (x == x1) ? t_ctrl'(y1) : t_ctrl'(y2);
        endfunction

        function void note_transfer(logic cmd, logic [INDEX_W-1:0] idx, t_angle ang,
                                    t_ctrl ctl, t_angle q);
            if (cmd == CMD_WRITE) begin
                writes_seen++;
                if (int'(idx) < PLT_MAX_POINTS) begin
                    bp_angle[idx] = ang;
                    bp_ctrl[idx]  = ctl;
                end
            end else begin
                lookups_seen++;
                expected_controls.push_back(interp_control(q));
            end
        endfunction

        function void check_result(t_ctrl got);
            t_ctrl exp_val;
            if (expected_controls.size() == 0) begin
                $error("control_value: result with no lookup pending, actual %0d", got);
                errors++;
                return;
            end
            exp_val = expected_controls.pop_front();
            results_checked++;
            if (got !== exp_val) begin
                $error("control_value mismatch: expected %0d, actual %0d", exp_val, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_command;
    logic [INDEX_W-1:0] i_entry_index;
    t_angle             i_entry_angle;
    t_ctrl              i_entry_control;
    t_angle             i_query_angle;
    logic               o_out_valid;
    logic               i_out_ready;
    t_ctrl              o_control_value;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_data;

    lookup_scoreboard sb;
    longint           tbl_angle[PLT_MAX_POINTS];
    bit               tx_idle_en    = 1'b1;
    bit               rx_idle_en    = 1'b1;
    int               rx_hold_req   = 0;
    int               settings_used = 0;
    int               idle_cycles   = 0;

    piecewise_linear_table_lookup_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_entry_index   (i_entry_index),
        .i_entry_angle   (i_entry_angle),
        .i_entry_control (i_entry_control),
        .i_query_angle   (i_query_angle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_control_value (o_control_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Output side: random stall bursts, plus one long hold-off on request
    initial begin
        int hold;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
                i_out_ready = 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Result check on every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_control_value);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic int eff_points(logic [COUNT_W-1:0] v);
        int n;
        n = v;
        if (n < POINT_COUNT_MIN) n = POINT_COUNT_MIN;
        if (n > PLT_MAX_POINTS) n = PLT_MAX_POINTS;
        return n;
    endfunction

    function automatic int rand_ctrl();
        case ($urandom_range(0, 7))
            0:       return CTRL_MIN;
            1:       return CTRL_MAX;
            default: return int'(t_ctrl'($urandom));
        endcase
    endfunction

    // One input transfer; valid held until accepted, then an optional gap
    task automatic send_item(logic cmd, int idx, longint ang, int ctl, longint q);
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_command       = cmd;
        i_entry_index   = idx[INDEX_W-1:0];
        i_entry_angle   = t_angle'(ang);
        i_entry_control = t_ctrl'(ctl);
        i_query_angle   = t_angle'(q);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_transfer(i_command, i_entry_index, i_entry_angle, i_entry_control,
                         i_query_angle);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_entry(int k, longint a, int c);
        tbl_angle[k] = longint'(t_angle'(a));
        send_item(CMD_WRITE, k, a, c, longint'($urandom));
    endtask

    // Unused fields of a lookup carry random noise
    task automatic lookup(longint q);
        send_item(CMD_LOOKUP, $urandom_range(0, PLT_MAX_POINTS - 1), longint'($urandom),
                  int'($urandom), q);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Register write only with the block idle
    task automatic set_points(logic [COUNT_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.load_points(v);
        settings_used++;
    endtask

    task automatic fill_table(t_fill mode, int n);
        longint a;
        a = 0;
        for (int k = 0; k < PLT_MAX_POINTS; k++) begin
            case (mode)
                FILL_SPREAD: begin
                    if (k == 0) begin
                        a = ANGLE_MIN + longint'($urandom_range(0, 32'h3FFF_FFFF));
                    end else begin
                        case ($urandom_range(0, 7))
                            0:       a += 0;
                            1:       a += 1;
                            2:       a += $urandom_range(2, 100);
                            default: a += $urandom_range(101, 1 << 26);
                        endcase
                    end
                end
                FILL_FULL_SPAN: begin
                    if (k >= n - 1) a = ANGLE_MAX;
                    else a = ANGLE_MIN + (longint'(k) * (ANGLE_MAX - ANGLE_MIN)) / (n - 1);
                end
                FILL_DENSE: begin
                    if (k == 0) a = longint'($urandom_range(0, 2000)) - 1000;
                    else a += $urandom_range(0, 5);
                end
                default: a = longint'(t_angle'($urandom));
            endcase
            write_entry(k, a, rand_ctrl());
        end
    endtask

    // Mostly inside a segment or next to a breakpoint, some clamps and wild values
    function automatic longint pick_query(int n);
        int     k;
        int     off;
        longint lo;
        longint hi;
        k   = $urandom_range(1, n - 1);
        off = $urandom_range(0, 6);
        lo  = (tbl_angle[k-1] < tbl_angle[k]) ? tbl_angle[k-1] : tbl_angle[k];
        hi  = (tbl_angle[k-1] < tbl_angle[k]) ? tbl_angle[k] : tbl_angle[k-1];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return lo + longint'($urandom) % (hi - lo + 1);
            4, 5:       return tbl_angle[$urandom_range(0, n - 1)] + off - 3;
            6: begin
                off = $urandom_range(0, 1000);
                if ($urandom_range(0, 1) == 0) return tbl_angle[0] - 1 - off;
                return tbl_angle[n-1] + 1 + off;
            end
            7:       return ($urandom_range(0, 1) == 0) ? ANGLE_MIN : ANGLE_MAX;
            default: return longint'(t_angle'($urandom));
        endcase
    endfunction

    // Mid-phase table update: new control, sometimes a new angle too
    task automatic rewrite_entry();
        int     k;
        longint a;
        k = $urandom_range(0, PLT_MAX_POINTS - 1);
        a = ($urandom_range(0, 3) == 0) ? longint'(t_angle'($urandom)) : tbl_angle[k];
        write_entry(k, a, rand_ctrl());
    endtask

    // Two points after reset: extremes, exact ends, zero span, clamps
    task automatic run_directed();
        write_entry(0, ANGLE_MIN, CTRL_MAX);
        write_entry(1, ANGLE_MAX, CTRL_MIN);
        lookup(ANGLE_MIN);
        lookup(ANGLE_MAX);
        lookup(0);
        lookup(1);
        lookup(-1);
        lookup(longint'(1) << 29);
        write_entry(0, 5, 1234);
        write_entry(1, 5, -4321);
        lookup(5);
        lookup(4);
        lookup(6);
        write_entry(0, -100, CTRL_MIN);
        write_entry(1, 100, CTRL_MAX);
        lookup(-101);
        lookup(101);
        lookup(-100);
        lookup(100);
        lookup(0);
        lookup(37);
    endtask

    task automatic run_phase(int p);
        logic [COUNT_W-1:0] cfg;
        int                 n;
        t_fill              mode;
        case (p)
            0:       cfg = COUNT_W'(16);
            1:       cfg = COUNT_W'(0);
            2:       cfg = COUNT_W'(31);
            3:       cfg = COUNT_W'(5);
            4:       cfg = COUNT_W'(1);
            5:       cfg = COUNT_W'(17);
            7:       cfg = COUNT_W'(2);
            9:       cfg = COUNT_W'(16);
            default: cfg = COUNT_W'($urandom_range(0, 31));
        endcase
        set_points(cfg);
        n = eff_points(cfg);
        // last phase runs without idling; phase 1 fills the block behind a long stall
        tx_idle_en = (p != NUM_PHASES - 1) && (p % 3 != 2) && (p != 1);
        rx_idle_en = (p != NUM_PHASES - 1) && (p % 4 != 1);
        if (p == 1) rx_hold_req = LONG_HOLD;
        case ($urandom_range(0, 5))
            2:       mode = FILL_FULL_SPAN;
            3:       mode = FILL_DENSE;
            4:       mode = FILL_SCRAMBLED;
            default: mode = FILL_SPREAD;
        endcase
        if (p == 2 || p == NUM_PHASES - 1) mode = FILL_FULL_SPAN;
        fill_table(mode, n);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 3 && k == PHASE_ITEMS / 2) drain();
            if ($urandom_range(0, 19) == 0) rewrite_entry();
            else lookup(pick_query(n));
        end
    endtask

    // Main sequence
    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_WRITE;
        i_entry_index   = '0;
        i_entry_angle   = '0;
        i_entry_control = '0;
        i_query_angle   = '0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d table writes and %0d lookups across %0d point-count settings,",
                 sb.writes_seen, sb.lookups_seen, settings_used);
        $display("%0d results compared under random gaps, stalls and a long output hold-off.",
                 sb.results_checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
